### src/drfp_pkg.sv
// Shared types, character codes and helper functions for the dispenser reply parser.
// No dependencies; imported by every module in src.
package drfp_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned FIRST_W  = 30;
   localparam int unsigned SECOND_W = 20;
   localparam int unsigned LEN_W    = BYTE_W + 1;

   // frame characters
   localparam logic [BYTE_W-1:0] CHAR_START = 8'h02;
   localparam logic [BYTE_W-1:0] CHAR_SEP   = 8'h3B;  // ';'
   localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [BYTE_W-1:0] CHAR_ONE   = 8'h31;
   localparam logic [BYTE_W-1:0] CMD_STATUS = 8'h53;  // 'S'
   localparam logic [BYTE_W-1:0] CMD_LIVE_V = 8'h4C;  // 'L'
   localparam logic [BYTE_W-1:0] CMD_LIVE_M = 8'h52;  // 'R'
   localparam logic [BYTE_W-1:0] CMD_FINAL  = 8'h54;  // 'T'
   localparam logic [BYTE_W-1:0] CMD_TOTAL  = 8'h43;  // 'C'

   // minimum frame lengths per command
   localparam logic [LEN_W-1:0] MIN_LEN_ANY    = 9'd5;
   localparam logic [LEN_W-1:0] MIN_LEN_STATUS = 9'd7;
   localparam logic [LEN_W-1:0] MIN_LEN_LIVE   = 9'd15;
   localparam logic [LEN_W-1:0] MIN_LEN_FINAL  = 9'd27;
   localparam logic [LEN_W-1:0] MIN_LEN_TOTAL  = 9'd16;

   // event kinds
   localparam logic [2:0] EV_STATUS = 3'd0;
   localparam logic [2:0] EV_LIVE_V = 3'd1;
   localparam logic [2:0] EV_LIVE_M = 3'd2;
   localparam logic [2:0] EV_FINAL  = 3'd3;
   localparam logic [2:0] EV_TOTAL  = 3'd4;

   // dense status codes
   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_CALLING   = 4'd1;
   localparam logic [3:0] ST_AUTH_WAIT = 4'd2;
   localparam logic [3:0] ST_STARTED   = 4'd3;
   localparam logic [3:0] ST_PAUSED    = 4'd4;
   localparam logic [3:0] ST_FUELLING  = 4'd5;
   localparam logic [3:0] ST_FINISHING = 4'd6;
   localparam logic [3:0] ST_FIN_HOLD  = 4'd7;
   localparam logic [3:0] ST_ERROR     = 4'd8;

   // CSR indexes
   localparam logic CSR_ADDR_HIGH = 1'b0;
   localparam logic CSR_ADDR_LOW  = 1'b1;

   typedef struct packed {
      logic [BYTE_W-1:0] rx_byte;
      logic              last_byte;
   } req_payload_type;

   typedef struct packed {
      logic                frame_ok;
      logic [2:0]          event_kind;
      logic [3:0]          status_code;
      logic [BYTE_W-1:0]   status_byte;
      logic [BYTE_W-1:0]   nozzle_byte;
      logic [BYTE_W-1:0]   transaction_tag;
      logic [FIRST_W-1:0]  volume_value;
      logic [SECOND_W-1:0] money_value;
   } rsp_payload_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   byte_position;
      logic [BYTE_W-1:0]   running_xor;
      logic                header_good;
      logic [BYTE_W-1:0]   command_letter;
      logic [BYTE_W-1:0]   byte_four;
      logic [BYTE_W-1:0]   byte_five;
      logic [BYTE_W-1:0]   byte_six;
      logic                body_good;
      logic [FIRST_W-1:0]  first_number;
      logic [SECOND_W-1:0] second_number;
   } frame_state_type;

   localparam frame_state_type FRAME_CLEAR = '{
      byte_position:  '0,
      running_xor:    '0,
      header_good:    1'b1,
      command_letter: '0,
      byte_four:      '0,
      byte_five:      '0,
      byte_six:       '0,
      body_good:      1'b1,
      first_number:   '0,
      second_number:  '0
   };

   function automatic logic is_digit(input logic [BYTE_W-1:0] b);
      return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
   endfunction

   // acc*10 + digit, kept to FIRST_W bits (shift-add)
   function automatic logic [FIRST_W-1:0] digit_step(input logic [FIRST_W-1:0] acc,
                                                     input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] d;
      d = b - CHAR_ZERO;
      return (acc << 3) + (acc << 1) + FIRST_W'(d[3:0]);
   endfunction

   function automatic logic [3:0] status_map(input logic [BYTE_W-1:0] c);
      logic [3:0] code;
      case (c)
         8'h31: code = ST_IDLE;
         8'h32: code = ST_CALLING;
         8'h33: code = ST_AUTH_WAIT;
         8'h34: code = ST_STARTED;
         8'h35: code = ST_PAUSED;
         8'h37: code = ST_PAUSED;
         8'h36: code = ST_FUELLING;
         8'h38: code = ST_FINISHING;
         8'h39: code = ST_FIN_HOLD;
         default: code = ST_ERROR;
      endcase
      return code;
   endfunction

endpackage

### src/dispenser_response_frame_parser_core.sv
// Dispenser reply frame parser, top level.
// Throughput: one byte beat per cycle, sustained while rsp_ready is high.
// The result for a frame appears in the output register in the cycle after its last
// byte is accepted; bytes without the last mark produce no result.
// Reset (synchronous, active high): frame state cleared, station address 0, no result.
// Depends on drfp_pkg, drfp_frame, drfp_result.
module dispenser_response_frame_parser_core (
   input  logic                      clock,
   input  logic                      reset,
   // request channel: one received byte per beat
   input  logic                      req_valid,
   output logic                      req_ready,
   input  drfp_pkg::req_payload_type req_payload,
   // response channel: one result per frame
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output drfp_pkg::rsp_payload_type rsp_payload,
   // configuration write port
   input  logic                      csr_write_enable,
   input  logic                      csr_index,
   input  logic [7:0]                csr_wdata
);
   import drfp_pkg::*;

   logic [BYTE_W-1:0] addr_high_ff, addr_low_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_payload_ff, rsp_payload_in;
   frame_state_type   next_state;
   logic [BYTE_W-1:0] pos_now;
   logic              accept;

   // The output register frees itself in the same cycle it is taken, so a
   // new byte can enter while a finished result is being consumed.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // Station address registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_high_ff <= '0;
         addr_low_ff  <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_ADDR_HIGH: addr_high_ff <= csr_wdata;
            CSR_ADDR_LOW:  addr_low_ff  <= csr_wdata;
            default:       addr_high_ff <= addr_high_ff;
         endcase
      end
   end

   // Per-byte tracking; next_state is the frame state including this beat.
   drfp_frame u_frame (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .beat       (req_payload),
      .addr_high  (addr_high_ff),
      .addr_low   (addr_low_ff),
      .next_state (next_state),
      .pos_now    (pos_now)
   );

   // Verdict and field mapping, evaluated on the last byte's beat.
   drfp_result u_result (
      .st      (next_state),
      .pos_now (pos_now),
      .result  (rsp_payload_in)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept && req_payload.last_byte) rsp_valid_in = 1'b1;
      else if (rsp_ready)                  rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload register: no reset needed, qualified by rsp_valid.
   always_ff @(posedge clock) begin
      if (accept && req_payload.last_byte) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

### src/drfp_frame.sv
// Per-byte frame tracker: header check, running XOR, field capture, digit accumulation.
// Depends on drfp_pkg.
module drfp_frame (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  drfp_pkg::req_payload_type beat,
   input  logic [7:0]               addr_high,
   input  logic [7:0]               addr_low,
   output drfp_pkg::frame_state_type next_state,
   output logic [7:0]               pos_now
);
   import drfp_pkg::*;

   frame_state_type state_ff, state_in;
   logic [BYTE_W-1:0] b, p, c;
   logic is_lrt, sep_pos;

   assign b       = beat.rx_byte;
   assign p       = state_ff.byte_position;
   assign c       = state_ff.command_letter;
   assign pos_now = p;
   assign is_lrt  = (c == CMD_LIVE_V) || (c == CMD_LIVE_M) || (c == CMD_FINAL);
   assign sep_pos = (p == 8'd14) || (p == 8'd21);

   always_comb begin
      state_in = state_ff;
      if (p == 8'd0) begin
         if (b != CHAR_START) state_in.header_good = 1'b0;
      end else begin
         state_in.running_xor = state_ff.running_xor ^ b;
         if (p == 8'd1) begin
            if (b != addr_high) state_in.header_good = 1'b0;
         end else if (p == 8'd2) begin
            if (b != addr_low) state_in.header_good = 1'b0;
         end else if (p == 8'd3) begin
            state_in.command_letter = b;
         end else begin
            if (p == 8'd4) state_in.byte_four = b;
            if (p == 8'd5) state_in.byte_five = b;
            if (p == 8'd6) state_in.byte_six  = b;
            // body checks by command
            if (is_lrt) begin
               if (p == 8'd7) begin
                  if (b != CHAR_SEP) state_in.body_good = 1'b0;
               end else if (p >= 8'd8 && p <= 8'd13) begin
                  if (is_digit(b)) state_in.first_number = digit_step(state_ff.first_number, b);
                  else state_in.body_good = 1'b0;
               end else if (c == CMD_FINAL) begin
                  if (sep_pos) begin
                     if (b != CHAR_SEP) state_in.body_good = 1'b0;
                  end else if (p >= 8'd15 && p <= 8'd20) begin
                     if (is_digit(b)) begin
                        state_in.second_number = SECOND_W'(
                           digit_step(FIRST_W'(state_ff.second_number), b));
                     end else begin
                        state_in.body_good = 1'b0;
                     end
                  end
               end
            end else if (c == CMD_TOTAL) begin
               if (p == 8'd4) begin
                  if (b != CHAR_ONE) state_in.body_good = 1'b0;
               end else if (p == 8'd5) begin
                  if (b != CHAR_SEP) state_in.body_good = 1'b0;
               end else if (p >= 8'd6 && p <= 8'd14) begin
                  if (is_digit(b)) state_in.first_number = digit_step(state_ff.first_number, b);
                  else state_in.body_good = 1'b0;
               end
            end
         end
      end
      if (p != 8'hFF) state_in.byte_position = p + 8'd1;
   end

   assign next_state = state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRAME_CLEAR;
      end else if (accept) begin
         state_ff <= beat.last_byte ? FRAME_CLEAR : state_in;
      end
   end

endmodule

### src/drfp_result.sv
// Frame verdict and result field selection from the state after the last byte.
// Depends on drfp_pkg.
module drfp_result (
   input  drfp_pkg::frame_state_type st,
   input  logic [7:0]                pos_now,
   output drfp_pkg::rsp_payload_type result
);
   import drfp_pkg::*;

   logic [LEN_W-1:0] len, min_len;
   logic ok;

   assign len = LEN_W'(pos_now) + LEN_W'(1);

   always_comb begin
      case (st.command_letter)
         CMD_STATUS: min_len = MIN_LEN_STATUS;
         CMD_LIVE_V: min_len = MIN_LEN_LIVE;
         CMD_LIVE_M: min_len = MIN_LEN_LIVE;
         CMD_FINAL:  min_len = MIN_LEN_FINAL;
         CMD_TOTAL:  min_len = MIN_LEN_TOTAL;
         default:    min_len = '0;
      endcase
   end

   assign ok = (len >= MIN_LEN_ANY) && st.header_good && (st.running_xor == '0) &&
               st.body_good && (min_len != '0) && (len >= min_len);

   always_comb begin
      result = '0;
      if (ok) begin
         result.frame_ok = 1'b1;
         case (st.command_letter)
            CMD_STATUS: begin
               result.event_kind  = EV_STATUS;
               result.status_code = status_map(st.byte_four);
               result.status_byte = st.byte_four;
               result.nozzle_byte = st.byte_five;
            end
            CMD_TOTAL: begin
               result.event_kind   = EV_TOTAL;
               result.volume_value = st.first_number;
            end
            default: begin
               result.status_code     = status_map(st.byte_six);
               result.status_byte     = st.byte_six;
               result.nozzle_byte     = st.byte_four;
               result.transaction_tag = st.byte_five;
               if (st.command_letter == CMD_LIVE_V) begin
                  result.event_kind   = EV_LIVE_V;
                  result.volume_value = st.first_number;
               end else if (st.command_letter == CMD_LIVE_M) begin
                  result.event_kind  = EV_LIVE_M;
                  result.money_value = st.first_number[SECOND_W-1:0];
               end else begin
                  result.event_kind   = EV_FINAL;
                  result.money_value  = st.first_number[SECOND_W-1:0];
                  result.volume_value = FIRST_W'(st.second_number);
               end
            end
         endcase
      end
   end

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for dispenser_response_frame_parser_core.
// Depends on drfp_pkg and the parser RTL. Frames go in as byte beats and a local
// decoder predicts each reply. Replies are compared field by field in arrival order.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import drfp_pkg::*;

   localparam int CYCLE_LIMIT = 300000;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_write_enable = 1'b0;
   logic            csr_index = CSR_ADDR_HIGH;
   logic [7:0]      csr_wdata = 8'h00;

   dispenser_response_frame_parser_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Parse state the decoder keeps between beats of one frame.
   typedef struct packed {
      logic [7:0]  offset;     // byte position, sticks at 255
      logic [7:0]  xor_sum;    // XOR of everything after the start byte
      logic        header_ok;
      logic [7:0]  letter;
      logic [7:0]  field4;
      logic [7:0]  field5;
      logic [7:0]  field6;
      logic        body_ok;
      logic [29:0] accum_a;    // first decimal field
      logic [19:0] accum_b;    // second decimal field (final reply volume)
   } frame_track_type;

   frame_track_type trk;
   logic [7:0]      station_hi = 8'h00;
   logic [7:0]      station_lo = 8'h00;
   rsp_payload_type expected_replies[$];
   logic [7:0]      frame_buf[$];

   int send_idle_pct = 21;
   int recv_idle_pct = 81;
   int hold_request  = 0;
   int hold_left     = 0;
   int sent_bytes    = 0;
   int reply_count   = 0;
   int error_count   = 0;
   int cycle_count   = 0;

   // ---------------------------------------------------------------- decoder
   function automatic frame_track_type clear_track();
      frame_track_type t;
      t           = '0;
      t.header_ok = 1'b1;
      t.body_ok   = 1'b1;
      return t;
   endfunction

   function automatic logic is_dec(input logic [7:0] b);
      return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
   endfunction

   // acc * 10 + digit, wrapped to 30 bits
   function automatic logic [29:0] shift_in(input logic [29:0] acc, input logic [7:0] b);
      return 30'(acc * 10 + (b - CHAR_ZERO));
   endfunction

   function automatic logic [3:0] dense_status(input logic [7:0] c);
      case (c)
         "1":      return ST_IDLE;
         "2":      return ST_CALLING;
         "3":      return ST_AUTH_WAIT;
         "4":      return ST_STARTED;
         "5", "7": return ST_PAUSED;
         "6":      return ST_FUELLING;
         "8":      return ST_FINISHING;
         "9":      return ST_FIN_HOLD;
         default:  return ST_ERROR;
      endcase
   endfunction

   // Advances the parse state by one accepted beat; on the last beat of a frame
   // produces the reply the block must give and starts a fresh frame.
   function automatic void track_byte(input logic [7:0] b, input logic last,
                                      output logic has_reply, output rsp_payload_type reply);
      logic [7:0]  p;
      int unsigned flen;
      int unsigned min_len;
      logic        good;
      p         = trk.offset;
      has_reply = last;
      reply     = '0;
      if (p == 8'd0) begin
         if (b != CHAR_START) trk.header_ok = 1'b0;
      end else begin
         trk.xor_sum ^= b;
         if (p == 8'd1) begin
            if (b != station_hi) trk.header_ok = 1'b0;
         end else if (p == 8'd2) begin
            if (b != station_lo) trk.header_ok = 1'b0;
         end else if (p == 8'd3) begin
            trk.letter = b;
         end else begin
            if (p == 8'd4) trk.field4 = b;
            if (p == 8'd5) trk.field5 = b;
            if (p == 8'd6) trk.field6 = b;
            if (trk.letter == CMD_LIVE_V || trk.letter == CMD_LIVE_M ||
                trk.letter == CMD_FINAL) begin
               if (p == 8'd7) begin
                  if (b != CHAR_SEP) trk.body_ok = 1'b0;
               end else if (p >= 8'd8 && p <= 8'd13) begin
                  if (is_dec(b)) trk.accum_a = shift_in(trk.accum_a, b);
                  else trk.body_ok = 1'b0;
               end else if (trk.letter == CMD_FINAL) begin
                  if (p == 8'd14 || p == 8'd21) begin
                     if (b != CHAR_SEP) trk.body_ok = 1'b0;
                  end else if (p >= 8'd15 && p <= 8'd20) begin
                     if (is_dec(b)) trk.accum_b = 20'(shift_in(30'(trk.accum_b), b));
                     else trk.body_ok = 1'b0;
                  end
               end
            end else if (trk.letter == CMD_TOTAL) begin
               if (p == 8'd4) begin
                  if (b != CHAR_ONE) trk.body_ok = 1'b0;
               end else if (p == 8'd5) begin
                  if (b != CHAR_SEP) trk.body_ok = 1'b0;
               end else if (p >= 8'd6 && p <= 8'd14) begin
                  if (is_dec(b)) trk.accum_a = shift_in(trk.accum_a, b);
                  else trk.body_ok = 1'b0;
               end
            end
         end
      end
      if (trk.offset != 8'hFF) trk.offset = trk.offset + 8'd1;
      if (!last) return;

      flen = int'(p) + 1;
      case (trk.letter)
         CMD_STATUS:             min_len = 32'(MIN_LEN_STATUS);
         CMD_LIVE_V, CMD_LIVE_M: min_len = 32'(MIN_LEN_LIVE);
         CMD_FINAL:              min_len = 32'(MIN_LEN_FINAL);
         CMD_TOTAL:              min_len = 32'(MIN_LEN_TOTAL);
         default:                min_len = 0;
      endcase
      good = (flen >= MIN_LEN_ANY) && trk.header_ok && (trk.xor_sum == 8'h00) &&
             trk.body_ok && (min_len != 0) && (flen >= min_len);
      if (good) begin
         reply.frame_ok = 1'b1;
         case (trk.letter)
            CMD_STATUS: begin
               reply.event_kind  = EV_STATUS;
               reply.status_code = dense_status(trk.field4);
               reply.status_byte = trk.field4;
               reply.nozzle_byte = trk.field5;
            end
            CMD_TOTAL: begin
               reply.event_kind   = EV_TOTAL;
               reply.volume_value = trk.accum_a;
            end
            default: begin
               // live and final replies: nozzle, tag, status, then digits
               reply.status_code     = dense_status(trk.field6);
               reply.status_byte     = trk.field6;
               reply.nozzle_byte     = trk.field4;
               reply.transaction_tag = trk.field5;
               if (trk.letter == CMD_LIVE_V) begin
                  reply.event_kind   = EV_LIVE_V;
                  reply.volume_value = trk.accum_a;
               end else if (trk.letter == CMD_LIVE_M) begin
                  reply.event_kind  = EV_LIVE_M;
                  reply.money_value = trk.accum_a[19:0];
               end else begin
                  reply.event_kind   = EV_FINAL;
                  reply.money_value  = trk.accum_a[19:0];
                  reply.volume_value = 30'(trk.accum_b);
               end
            end
         endcase
      end
      trk = clear_track();
   endfunction

   // ---------------------------------------------------------------- checking
   task automatic flag_error(input string msg);
      error_count++;
      $display("mismatch: %s", msg);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         flag_error($sformatf("reply %0d %s got 0x%0h want 0x%0h",
                              reply_count, name, got, want));
   endtask

   always @(posedge clock) begin : reply_check
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         reply_count++;
         if (expected_replies.size() == 0) begin
            flag_error($sformatf("reply %0d arrived with nothing pending", reply_count));
         end else begin
            want = expected_replies.pop_front();
            check_field("frame_ok", 32'(rsp_payload.frame_ok), 32'(want.frame_ok));
            check_field("event_kind", 32'(rsp_payload.event_kind), 32'(want.event_kind));
            check_field("status_code", 32'(rsp_payload.status_code),
                        32'(want.status_code));
            check_field("status_byte", 32'(rsp_payload.status_byte),
                        32'(want.status_byte));
            check_field("nozzle_byte", 32'(rsp_payload.nozzle_byte),
                        32'(want.nozzle_byte));
            check_field("transaction_tag", 32'(rsp_payload.transaction_tag),
                        32'(want.transaction_tag));
            check_field("volume_value", 32'(rsp_payload.volume_value),
                        32'(want.volume_value));
            check_field("money_value", 32'(rsp_payload.money_value),
                        32'(want.money_value));
         end
      end
   end

   // Receiver: random back-pressure, or a long hold-off when a test asks for one.
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d replies pending",
                  cycle_count, expected_replies.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ---------------------------------------------------------------- driving
   // One byte beat. Valid is only dropped when a gap is taken, so it is never
   // lowered and raised again in the same step.
   task automatic send_byte(input logic [7:0] b, input logic last);
      logic            has;
      rsp_payload_type r;
      if (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{rx_byte: b, last_byte: last};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_bytes++;
      track_byte(b, last, has, r);
      if (has) expected_replies.push_back(r);
   endtask

   task automatic send_frame();
      int i;
      for (i = 0; i < frame_buf.size(); i++)
         send_byte(frame_buf[i], i == frame_buf.size() - 1);
   endtask

   // Quiet the input, let every pending reply out, then a few spare cycles.
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Both address registers in back-to-back write cycles; only called when idle.
   task automatic set_station(input logic [7:0] hi, input logic [7:0] lo);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_ADDR_HIGH;
      csr_wdata        <= hi;
      @(posedge clock);
      csr_index <= CSR_ADDR_LOW;
      csr_wdata <= lo;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      station_hi = hi;
      station_lo = lo;
   endtask

   // ---------------------------------------------------------------- frame building
   task automatic put(input logic [7:0] b);
      frame_buf.push_back(b);
   endtask

   task automatic begin_frame(input logic [7:0] letter);
      frame_buf.delete();
      put(CHAR_START);
      put(station_hi);
      put(station_lo);
      put(letter);
   endtask

   task automatic put_digits(input int n);
      repeat (n) put(8'(CHAR_ZERO + $urandom_range(9, 0)));
   endtask

   task automatic put_number(input int unsigned v, input int n);
      int unsigned scale;
      scale = 1;
      repeat (n - 1) scale *= 10;
      repeat (n) begin
         put(8'(CHAR_ZERO + (v / scale) % 10));
         scale /= 10;
      end
   endtask

   task automatic seal_frame();
      logic [7:0] x;
      int         i;
      x = 8'h00;
      for (i = 1; i < frame_buf.size(); i++) x ^= frame_buf[i];
      frame_buf.push_back(x);
   endtask

   task automatic reseal();
      void'(frame_buf.pop_back());
      seal_frame();
   endtask

   function automatic logic [7:0] status_char();
      if ($urandom_range(9, 0) < 8) return 8'($urandom_range(CHAR_NINE + 1, CHAR_ZERO));
      return 8'($urandom);
   endfunction

   function automatic logic [7:0] any_letter();
      case ($urandom_range(4, 0))
         0:       return CMD_STATUS;
         1:       return CMD_LIVE_V;
         2:       return CMD_LIVE_M;
         3:       return CMD_FINAL;
         default: return CMD_TOTAL;
      endcase
   endfunction

   // Well-formed reply with random content and sometimes trailing filler.
   task automatic build_good(input logic [7:0] letter);
      begin_frame(letter);
      if (letter == CMD_STATUS) begin
         put(status_char());
         put(8'($urandom));
      end else if (letter == CMD_TOTAL) begin
         put(CHAR_ONE);
         put(CHAR_SEP);
         put_digits(9);
      end else begin
         put(8'($urandom));
         put(8'($urandom));
         put(status_char());
         put(CHAR_SEP);
         put_digits(6);
         if (letter == CMD_FINAL) begin
            put(CHAR_SEP);
            put_digits(6);
            put(CHAR_SEP);
            repeat (4) put(8'($urandom));   // final reply needs 27 bytes
         end
      end
      if ($urandom_range(3, 0) == 0) repeat ($urandom_range(3, 1)) put(8'($urandom));
      seal_frame();
   endtask

   // Break a built frame: checksum, one byte, length or command letter.
   task automatic mangle();
      int keep;
      case ($urandom_range(3, 0))
         0: frame_buf[frame_buf.size() - 1] ^= 8'($urandom_range(255, 1));
         1: begin
            frame_buf[$urandom_range(frame_buf.size() - 2, 0)] = 8'($urandom);
            reseal();
         end
         2: begin
            keep = $urandom_range(frame_buf.size() - 2, 1);
            while (frame_buf.size() > keep) void'(frame_buf.pop_back());
            seal_frame();
         end
         default: begin
            frame_buf[3] = 8'($urandom);
            reseal();
         end
      endcase
   endtask

   // ---------------------------------------------------------------- tests
   // Every reply kind with field extremes, at the reset station address.
   task automatic test_reply_decoding();
      begin_frame(CMD_STATUS); put("1"); put("1"); seal_frame(); send_frame();
      begin_frame(CMD_STATUS); put("9"); put(8'hFF); seal_frame(); send_frame();
      // status outside the table maps to the error code
      begin_frame(CMD_STATUS); put(8'h00); put(8'h00); seal_frame(); send_frame();
      begin_frame(CMD_LIVE_V);
      put("1"); put(8'hFF); put("6"); put(CHAR_SEP); put_number(999999, 6);
      seal_frame(); send_frame();
      begin_frame(CMD_LIVE_M);
      put("2"); put("A"); put("7"); put(CHAR_SEP); put_number(0, 6);
      seal_frame(); send_frame();
      begin_frame(CMD_FINAL);
      put("3"); put(8'h00); put("8"); put(CHAR_SEP); put_number(999999, 6);
      put(CHAR_SEP); put_number(999999, 6); put(CHAR_SEP);
      repeat (4) put(8'hFF);
      seal_frame(); send_frame();
      begin_frame(CMD_TOTAL); put(CHAR_ONE); put(CHAR_SEP); put_number(999999999, 9);
      seal_frame(); send_frame();
      begin_frame(CMD_TOTAL); put(CHAR_ONE); put(CHAR_SEP); put_number(0, 9);
      seal_frame(); send_frame();
      // long frame: position counter saturates, filler only feeds the checksum
      begin_frame(CMD_STATUS); put("5"); put("4");
      repeat (300) put(8'($urandom));
      seal_frame(); send_frame();
   endtask

   // Frames that must come back as an all-zero reply.
   task automatic test_frame_errors();
      // lone start byte, then a 4-byte frame: both under the 5-byte floor
      frame_buf.delete(); put(CHAR_START); send_frame();
      frame_buf.delete(); put(CHAR_START); put(station_hi); put(station_lo);
      seal_frame(); send_frame();
      // status reply one byte short
      begin_frame(CMD_STATUS); put("1"); seal_frame(); send_frame();
      // final reply at 26 bytes
      begin_frame(CMD_FINAL);
      put("1"); put("1"); put("1"); put(CHAR_SEP); put_digits(6);
      put(CHAR_SEP); put_digits(6); put(CHAR_SEP); repeat (3) put("0");
      seal_frame(); send_frame();
      // unknown command letter
      begin_frame("Q"); repeat (12) put(8'($urandom)); seal_frame(); send_frame();
      // bad checksum
      build_good(CMD_LIVE_V); frame_buf[frame_buf.size() - 1] ^= 8'h01; send_frame();
      // wrong start byte (start is outside the checksum)
      build_good(CMD_STATUS); frame_buf[0] = 8'h03; send_frame();
      // digit fields: characters just above and below the digit range
      build_good(CMD_LIVE_M); frame_buf[10] = CHAR_NINE + 8'd1; reseal(); send_frame();
      build_good(CMD_FINAL); frame_buf[17] = CHAR_ZERO - 8'd1; reseal(); send_frame();
      // separators
      build_good(CMD_FINAL); frame_buf[14] = ","; reseal(); send_frame();
      build_good(CMD_FINAL); frame_buf[21] = ","; reseal(); send_frame();
      build_good(CMD_LIVE_V); frame_buf[7] = ","; reseal(); send_frame();
      // totalizer needs '1' then ';'
      build_good(CMD_TOTAL); frame_buf[4] = "2"; reseal(); send_frame();
      build_good(CMD_TOTAL); frame_buf[5] = ","; reseal(); send_frame();
   endtask

   // Address registers at their extremes, matching and mismatching frames.
   task automatic test_station_address();
      drain();
      set_station(8'hFF, 8'h00);
      build_good(CMD_STATUS); send_frame();
      build_good(CMD_STATUS); frame_buf[1] = 8'hFE; reseal(); send_frame();
      drain();
      set_station(8'h00, 8'hFF);
      build_good(CMD_LIVE_V); send_frame();
      build_good(CMD_LIVE_V); frame_buf[2] = 8'h7F; reseal(); send_frame();
      drain();
      set_station(8'hFF, 8'hFF);
      build_good(CMD_STATUS); send_frame();
      build_good(CMD_LIVE_V); send_frame();
      build_good(CMD_LIVE_M); send_frame();
      build_good(CMD_FINAL); send_frame();
      build_good(CMD_TOTAL); send_frame();
   endtask

   // Mostly well-formed replies, some broken ones, some plain line noise.
   task automatic test_random_mix(input int send_idle, input int recv_idle,
                                  input int byte_budget, input logic [7:0] hi,
                                  input logic [7:0] lo);
      int stop_at;
      int pick;
      drain();
      set_station(hi, lo);
      send_idle_pct = send_idle;
      recv_idle_pct = recv_idle;
      stop_at       = sent_bytes + byte_budget;
      while (sent_bytes < stop_at) begin
         pick = $urandom_range(99, 0);
         if (pick < 10) begin
            frame_buf.delete();
            repeat ($urandom_range(20, 1)) put(8'($urandom));
            if ($urandom_range(1, 0) == 1) frame_buf[0] = CHAR_START;
         end else begin
            build_good(any_letter());
            if (pick < 30) mangle();
         end
         send_frame();
      end
   endtask

   // Receiver holds off for a long stretch while bytes keep coming, so the
   // block fills up and has to stall its input.
   task automatic test_output_stall();
      drain();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request  = 300;
      @(posedge clock);
      repeat (12) begin
         build_good(CMD_STATUS);
         send_frame();
      end
   endtask

   initial begin
      trk = clear_track();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_reply_decoding();
      test_frame_errors();
      test_station_address();
      test_random_mix(21, 81, 365, 8'($urandom), 8'($urandom));
      test_random_mix(81, 21, 365, 8'($urandom), 8'($urandom));
      test_random_mix(0, 0, 365, 8'($urandom), 8'($urandom));
      test_output_stall();

      drain();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
